// ----- sv/tesp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tesp_pkg;

   localparam int unsigned MAX_TYPES_DEF = 7;

   localparam int unsigned CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TYPE_COUNT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TYPE_LIST  = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_SHORT     = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;
   localparam logic [1:0] ST_BAD_TYPE  = 2'd3;

   typedef enum logic [2:0] {
      PH_TYPE = 3'd0,
      PH_TEXT = 3'd1,
      PH_LEN  = 3'd2,
      PH_BODY = 3'd3,
      PH_REST = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       article_end;
   } req_type;

   typedef struct packed {
      logic [7:0] content;
      logic       content_valid;
      logic [7:0] entry_type;
      logic       entry_first;
      logic       entry_last;
      logic       article_done;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  type_count;
      logic [55:0] type_list;
   } cfg_type;

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= 8'h61) && (c <= 8'h7a);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5a);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return is_lower(c) || is_upper(c);
   endfunction

   function automatic logic [7:0] listed_type(input logic [55:0] list, input logic [2:0] idx);
      logic [7:0] t;
      case (idx)
         3'd0: t = list[7:0];
         3'd1: t = list[15:8];
         3'd2: t = list[23:16];
         3'd3: t = list[31:24];
         3'd4: t = list[39:32];
         3'd5: t = list[47:40];
         3'd6: t = list[55:48];
         default: t = 8'h00;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

// ----- sv/tesp_in_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tesp_in_reg (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  tesp_pkg::req_type req_word,
   input  wire               advance,
   output logic              in_valid,
   output tesp_pkg::req_type in_word
);

   logic              valid_ff;
   logic              valid_in;
   tesp_pkg::req_type word_ff;
   logic              load;

   assign load      = !valid_ff || advance;
   assign req_stall = valid_ff && !advance;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= req_word;
      end
   end

   assign in_valid = valid_ff;
   assign in_word  = word_ff;

endmodule

`default_nettype wire

// ----- sv/tesp_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tesp_core #(
   parameter int unsigned MAX_TYPES = tesp_pkg::MAX_TYPES_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               fire,
   input  tesp_pkg::req_type in_word,
   input  tesp_pkg::cfg_type cfg,
   output tesp_pkg::rsp_type result
);

   localparam logic [2:0] MaxTypesC = 3'(MAX_TYPES);

   tesp_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  seq_ff, seq_in;
   logic [31:0] left_ff, left_in;
   logic [1:0]  pc_ff, pc_in;
   logic [7:0]  ctype_ff, ctype_in;
   logic        err_ff, err_in;
   logic [7:0]  held_ff, held_in;
   logic        hv_ff, hv_in;
   logic        fp_ff, fp_in;

   logic [2:0]  n;
   logic [2:0]  nm1;
   logic        listed;
   logic [7:0]  b;
   logic        art_end;
   logic [1:0]  err;
   logic [1:0]  status;
   logic        consumed;
   logic        completed;
   logic        cv, cf, cl;
   logic [7:0]  cb;
   logic [2:0]  s;
   logic [7:0]  t;
   logic        last_entry;

   assign n       = (cfg.type_count > MaxTypesC) ? MaxTypesC : cfg.type_count;
   assign nm1     = n - 3'd1;
   assign listed  = (n != 3'd0);
   assign b       = in_word.data_byte;
   assign art_end = in_word.article_end;

   // next state
   always_comb begin
      phase_in  = phase_ff;
      seq_in    = seq_ff;
      left_in   = left_ff;
      pc_in     = pc_ff;
      ctype_in  = ctype_ff;
      err_in    = err_ff;
      held_in   = held_ff;
      hv_in     = hv_ff;
      fp_in     = fp_ff;
      err       = tesp_pkg::ST_OK;
      status    = tesp_pkg::ST_OK;
      consumed  = 1'b0;
      completed = 1'b0;
      cv        = 1'b0;
      cf        = 1'b0;
      cl        = 1'b0;
      cb        = 8'h00;
      s         = (seq_ff > nm1) ? nm1 : seq_ff;
      t         = listed ? tesp_pkg::listed_type(cfg.type_list, s) : b;
      last_entry = listed && (s == nm1);

      if (!err_ff) begin
         if (phase_ff == tesp_pkg::PH_TYPE) begin
            consumed = !listed;
            ctype_in = t;
            fp_in    = 1'b1;
            hv_in    = 1'b0;
            if (!tesp_pkg::is_letter(t)) begin
               err = tesp_pkg::ST_BAD_TYPE;
            end else if (last_entry) begin
               phase_in = tesp_pkg::PH_REST;
            end else if (tesp_pkg::is_lower(t)) begin
               phase_in = tesp_pkg::PH_TEXT;
            end else begin
               phase_in = tesp_pkg::PH_LEN;
               pc_in    = 2'd0;
               left_in  = 32'd0;
            end
            if (consumed && (err == tesp_pkg::ST_OK) && art_end) begin
               err = tesp_pkg::ST_MALFORMED;
            end
         end

         if ((err == tesp_pkg::ST_OK) && !consumed) begin
            case (phase_in)
               tesp_pkg::PH_TEXT: begin
                  if (b != 8'h00) begin
                     if (hv_in) begin
                        cv    = 1'b1;
                        cb    = held_in;
                        cf    = fp_in;
                        fp_in = 1'b0;
                     end
                     held_in = b;
                     hv_in   = 1'b1;
                     if (art_end) begin
                        err = tesp_pkg::ST_MALFORMED;
                     end
                  end else begin
                     if (hv_in) begin
                        cv = 1'b1;
                        cb = held_in;
                        cf = fp_in;
                     end else begin
                        cf = 1'b1;
                     end
                     cl        = 1'b1;
                     hv_in     = 1'b0;
                     completed = 1'b1;
                  end
               end
               tesp_pkg::PH_LEN: begin
                  left_in = {left_in[23:0], b};
                  if (pc_in == 2'd3) begin
                     pc_in = 2'd0;
                     if (left_in == 32'd0) begin
                        cf        = 1'b1;
                        cl        = 1'b1;
                        completed = 1'b1;
                     end else begin
                        phase_in = tesp_pkg::PH_BODY;
                     end
                  end else begin
                     pc_in = pc_in + 2'd1;
                  end
                  if (art_end && !completed) begin
                     err = tesp_pkg::ST_MALFORMED;
                  end
               end
               tesp_pkg::PH_BODY: begin
                  if (left_in != 32'd0) begin
                     left_in = left_in - 32'd1;
                  end
                  cv    = 1'b1;
                  cb    = b;
                  cf    = fp_in;
                  fp_in = 1'b0;
                  if (left_in == 32'd0) begin
                     cl        = 1'b1;
                     completed = 1'b1;
                  end else if (art_end) begin
                     err = tesp_pkg::ST_MALFORMED;
                  end
               end
               default: begin
                  cv    = 1'b1;
                  cb    = b;
                  cf    = fp_in;
                  fp_in = 1'b0;
                  cl    = art_end;
               end
            endcase
         end

         if (err != tesp_pkg::ST_OK) begin
            cv     = 1'b0;
            cb     = 8'h00;
            cf     = 1'b0;
            cl     = 1'b0;
            status = err;
            err_in = !art_end;
         end else if (completed) begin
            phase_in = tesp_pkg::PH_TYPE;
            fp_in    = 1'b1;
            if (listed && (seq_in != 3'd7)) begin
               seq_in = seq_in + 3'd1;
            end
            if (art_end && listed) begin
               if (seq_in < nm1) begin
                  status = tesp_pkg::ST_SHORT;
               end else if ((seq_in == nm1) &&
                            !tesp_pkg::is_letter(tesp_pkg::listed_type(cfg.type_list, seq_in))) begin
                  status = tesp_pkg::ST_BAD_TYPE;
               end
            end
         end
      end

      // article end: everything but the current type goes back to reset
      if (art_end) begin
         phase_in = tesp_pkg::PH_TYPE;
         seq_in   = 3'd0;
         left_in  = 32'd0;
         pc_in    = 2'd0;
         err_in   = 1'b0;
         held_in  = 8'h00;
         hv_in    = 1'b0;
         fp_in    = 1'b1;
      end
   end

   // result word
   always_comb begin
      result.content       = cv ? cb : 8'h00;
      result.content_valid = cv;
      result.entry_type    = ctype_in;
      result.entry_first   = cf;
      result.entry_last    = cl;
      result.article_done  = art_end;
      result.status        = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tesp_pkg::PH_TYPE;
         seq_ff   <= 3'd0;
         left_ff  <= 32'd0;
         pc_ff    <= 2'd0;
         ctype_ff <= 8'h00;
         err_ff   <= 1'b0;
         held_ff  <= 8'h00;
         hv_ff    <= 1'b0;
         fp_ff    <= 1'b1;
      end else if (fire) begin
         phase_ff <= phase_in;
         seq_ff   <= seq_in;
         left_ff  <= left_in;
         pc_ff    <= pc_in;
         ctype_ff <= ctype_in;
         err_ff   <= err_in;
         held_ff  <= held_in;
         hv_ff    <= hv_in;
         fp_ff    <= fp_in;
      end
   end

   a_drop_no_content: assert property (@(posedge clock) disable iff (reset)
      fire && err_ff |-> !result.content_valid && (result.status == tesp_pkg::ST_OK))
      else $error("content passed while dropping an article");

   a_malformed_no_content: assert property (@(posedge clock) disable iff (reset)
      fire && (result.status == tesp_pkg::ST_MALFORMED) |-> !result.content_valid)
      else $error("malformed status carried content");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && in_word.article_end |=>
         (phase_ff == tesp_pkg::PH_TYPE) && (seq_ff == 3'd0) && !err_ff && !hv_ff)
      else $error("parse state not restarted after article end");

   a_drop_latch: assert property (@(posedge clock) disable iff (reset)
      fire && !err_ff && !in_word.article_end &&
      ((result.status == tesp_pkg::ST_MALFORMED) || (result.status == tesp_pkg::ST_BAD_TYPE))
      |=> err_ff)
      else $error("error not latched");

endmodule

`default_nettype wire

// ----- sv/tesp_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tesp_out_reg (
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   input  tesp_pkg::rsp_type in_word,
   output logic              advance,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output tesp_pkg::rsp_type rsp_word
);

   logic              valid_ff;
   tesp_pkg::rsp_type word_ff;

   assign advance = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         word_ff <= in_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

`default_nettype wire

// ----- sv/typed_entry_stream_parser_top.sv -----
// Typed entry parser: splits an article byte stream into typed entries.
// req_*: one article byte per word, req_article_end on the final byte.
// rsp_*: exactly one result word per request word, in order, carrying the
//        body byte (if any), entry type, first/last flags, article_done
//        and a status code.
// csr_*: register writes (type_count, type_list); csr_ready is always high.
//        Write only while no article byte is in flight.
// Path: the accepted request word is held in the input register, the parse
//        logic works on it combinationally, and its result is loaded into
//        the result register that drives rsp_*.
// Throughput: one word per cycle while rsp_stall is low; the parse state
//        loop closes through the core's next-state logic.
// Stall: rsp_stall holds a full result register; an empty input register
//        still takes one more word, and once it holds a word req_stall
//        follows rsp_stall in the same cycle.
// Reset: clears both registers' valid bits, the parse state and the
//        configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module typed_entry_stream_parser_top #(
   parameter int unsigned MAX_TYPES = tesp_pkg::MAX_TYPES_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [7:0]                           req_data_byte,
   input  wire                                  req_article_end,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [7:0]                           rsp_content,
   output logic                                 rsp_content_valid,
   output logic [7:0]                           rsp_entry_type,
   output logic                                 rsp_entry_first,
   output logic                                 rsp_entry_last,
   output logic                                 rsp_article_done,
   output logic [1:0]                           rsp_status,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [tesp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire  [55:0]                          csr_data
);

   tesp_pkg::req_type req_word;
   tesp_pkg::req_type in_word;
   tesp_pkg::rsp_type core_word;
   tesp_pkg::rsp_type rsp_word;
   tesp_pkg::cfg_type cfg_ff;
   logic              in_valid;
   logic              advance;
   logic              fire;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tesp_pkg::CSR_TYPE_COUNT: cfg_ff.type_count <= csr_data[2:0];
            tesp_pkg::CSR_TYPE_LIST:  cfg_ff.type_list  <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_word.data_byte   = req_data_byte;
   assign req_word.article_end = req_article_end;

   tesp_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_word   (in_word)
   );

   assign fire = in_valid && advance;

   tesp_core #(
      .MAX_TYPES (MAX_TYPES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_word (in_word),
      .cfg     (cfg_ff),
      .result  (core_word)
   );

   tesp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_word   (core_word),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_content       = rsp_word.content;
   assign rsp_content_valid = rsp_word.content_valid;
   assign rsp_entry_type    = rsp_word.entry_type;
   assign rsp_entry_first   = rsp_word.entry_first;
   assign rsp_entry_last    = rsp_word.entry_last;
   assign rsp_article_done  = rsp_word.article_done;
   assign rsp_status        = rsp_word.status;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int STUCK_LIMIT = 2000;

   logic                                 clock;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [7:0]                           req_data_byte = 8'h00;
   logic                                 req_article_end = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [7:0]                           rsp_content;
   logic                                 rsp_content_valid;
   logic [7:0]                           rsp_entry_type;
   logic                                 rsp_entry_first;
   logic                                 rsp_entry_last;
   logic                                 rsp_article_done;
   logic [1:0]                           rsp_status;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [tesp_pkg::CSR_INDEX_WIDTH-1:0] csr_index = tesp_pkg::CSR_TYPE_COUNT;
   logic [55:0]                          csr_data = 56'h0;

   typed_entry_stream_parser_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_article_end   (req_article_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_content       (rsp_content),
      .rsp_content_valid (rsp_content_valid),
      .rsp_entry_type    (rsp_entry_type),
      .rsp_entry_first   (rsp_entry_first),
      .rsp_entry_last    (rsp_entry_last),
      .rsp_article_done  (rsp_article_done),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // parser mirror
   logic [2:0]          cfg_count;
   logic [55:0]         cfg_list;
   tesp_pkg::phase_type parse_phase;
   logic [2:0]          entry_index;
   logic [31:0]         body_left;
   logic [1:0]          len_bytes;
   logic [7:0]          cur_type;
   logic                article_dropped;
   logic [7:0]          text_hold;
   logic                text_hold_v;
   logic                next_is_first;

   tesp_pkg::rsp_type   expected_rsp[$];
   logic [7:0]          art_bytes[$];
   int                  first_entry_end;
   int                  mismatch_count = 0;
   int                  sent_count = 0;
   int                  burst_left = 0;
   int                  gap_max = 0;
   int                  burst_max = 1;
   int                  stall_pct = 0;
   int                  hold_len = 0;
   int                  hold_trigger = 0;
   int                  hold_seen = 0;
   int                  hold_left = 0;
   int                  stuck_cycles = 0;
   tesp_pkg::rsp_type   got_rsp;
   tesp_pkg::rsp_type   want_rsp;

   function automatic logic lc_letter(input logic [7:0] c);
      return c >= 8'h61 && c <= 8'h7a;
   endfunction

   function automatic logic uc_letter(input logic [7:0] c);
      return c >= 8'h41 && c <= 8'h5a;
   endfunction

   function automatic logic any_letter(input logic [7:0] c);
      return lc_letter(c) || uc_letter(c);
   endfunction

   function automatic logic [7:0] list_entry(input int idx);
      logic [55:0] sh;
      sh = cfg_list >> (8 * idx);
      return sh[7:0];
   endfunction

   function automatic void restart_parse();
      parse_phase     = tesp_pkg::PH_TYPE;
      entry_index     = 3'd0;
      body_left       = 32'd0;
      len_bytes       = 2'd0;
      article_dropped = 1'b0;
      text_hold       = 8'h00;
      text_hold_v     = 1'b0;
      next_is_first   = 1'b1;
   endfunction

   function automatic tesp_pkg::rsp_type parse_byte(input logic [7:0] b, input logic fin);
      tesp_pkg::rsp_type r;
      logic [2:0] n;
      logic [2:0] s;
      logic [7:0] t;
      logic       listed;
      logic       last_entry;
      logic       consumed;
      logic       completed;
      logic       cv;
      logic       cf;
      logic       cl;
      logic [7:0] cb;
      logic [1:0] err;
      logic [1:0] st;
      n = cfg_count;
      listed = n != 3'd0;
      last_entry = 1'b0;
      consumed = 1'b0;
      completed = 1'b0;
      cv = 1'b0;
      cf = 1'b0;
      cl = 1'b0;
      cb = 8'h00;
      err = tesp_pkg::ST_OK;
      st = tesp_pkg::ST_OK;
      r.content = 8'h00;
      r.content_valid = 1'b0;
      r.entry_first = 1'b0;
      r.entry_last = 1'b0;
      r.article_done = fin;
      r.status = tesp_pkg::ST_OK;
      if (article_dropped) begin
         if (fin) restart_parse();
         r.entry_type = cur_type;
         return r;
      end
      if (parse_phase == tesp_pkg::PH_TYPE) begin
         if (listed) begin
            s = (entry_index > n - 3'd1) ? n - 3'd1 : entry_index;
            t = list_entry(s);
            last_entry = s == n - 3'd1;
         end else begin
            t = b;
            consumed = 1'b1;
         end
         cur_type = t;
         next_is_first = 1'b1;
         text_hold_v = 1'b0;
         if (!any_letter(t)) begin
            err = tesp_pkg::ST_BAD_TYPE;
         end else if (last_entry) begin
            parse_phase = tesp_pkg::PH_REST;
         end else if (lc_letter(t)) begin
            parse_phase = tesp_pkg::PH_TEXT;
         end else begin
            parse_phase = tesp_pkg::PH_LEN;
            len_bytes = 2'd0;
            body_left = 32'd0;
         end
         if (consumed && err == tesp_pkg::ST_OK && fin) err = tesp_pkg::ST_MALFORMED;
      end
      if (err == tesp_pkg::ST_OK && !consumed) begin
         case (parse_phase)
            tesp_pkg::PH_TEXT: begin
               if (b != 8'h00) begin
                  if (text_hold_v) begin
                     cv = 1'b1;
                     cb = text_hold;
                     cf = next_is_first;
                     next_is_first = 1'b0;
                  end
                  text_hold = b;
                  text_hold_v = 1'b1;
                  if (fin) err = tesp_pkg::ST_MALFORMED;
               end else begin
                  if (text_hold_v) begin
                     cv = 1'b1;
                     cb = text_hold;
                     cf = next_is_first;
                  end else begin
                     cf = 1'b1;
                  end
                  cl = 1'b1;
                  text_hold_v = 1'b0;
                  completed = 1'b1;
               end
            end
            tesp_pkg::PH_LEN: begin
               body_left = {body_left[23:0], b};
               if (len_bytes == 2'd3) begin
                  len_bytes = 2'd0;
                  if (body_left == 32'd0) begin
                     cf = 1'b1;
                     cl = 1'b1;
                     completed = 1'b1;
                  end else begin
                     parse_phase = tesp_pkg::PH_BODY;
                  end
               end else begin
                  len_bytes++;
               end
               if (fin && !completed) err = tesp_pkg::ST_MALFORMED;
            end
            tesp_pkg::PH_BODY: begin
               if (body_left != 32'd0) body_left--;
               cv = 1'b1;
               cb = b;
               cf = next_is_first;
               next_is_first = 1'b0;
               if (body_left == 32'd0) begin
                  cl = 1'b1;
                  completed = 1'b1;
               end else if (fin) begin
                  err = tesp_pkg::ST_MALFORMED;
               end
            end
            default: begin
               cv = 1'b1;
               cb = b;
               cf = next_is_first;
               next_is_first = 1'b0;
               cl = fin;
            end
         endcase
      end
      if (err != tesp_pkg::ST_OK) begin
         cv = 1'b0;
         cb = 8'h00;
         cf = 1'b0;
         cl = 1'b0;
         st = err;
         if (fin) restart_parse();
         else article_dropped = 1'b1;
      end else begin
         if (completed) begin
            parse_phase = tesp_pkg::PH_TYPE;
            next_is_first = 1'b1;
            if (listed && entry_index < 3'd7) entry_index++;
            if (fin && listed) begin
               if (entry_index < n - 3'd1) st = tesp_pkg::ST_SHORT;
               else if (entry_index == n - 3'd1 && !any_letter(list_entry(entry_index)))
                  st = tesp_pkg::ST_BAD_TYPE;
            end
         end
         if (fin) restart_parse();
      end
      r.content = cv ? cb : 8'h00;
      r.content_valid = cv;
      r.entry_type = cur_type;
      r.entry_first = cf;
      r.entry_last = cl;
      r.status = st;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_rsp.content = rsp_content;
         got_rsp.content_valid = rsp_content_valid;
         got_rsp.entry_type = rsp_entry_type;
         got_rsp.entry_first = rsp_entry_first;
         got_rsp.entry_last = rsp_entry_last;
         got_rsp.article_done = rsp_article_done;
         got_rsp.status = rsp_status;
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected result word, content", rsp_content, 8'h00);
         end else begin
            want_rsp = expected_rsp.pop_front();
            if (got_rsp.content !== want_rsp.content)
               report_mismatch("content", got_rsp.content, want_rsp.content);
            if (got_rsp.content_valid !== want_rsp.content_valid)
               report_mismatch("content_valid", got_rsp.content_valid, want_rsp.content_valid);
            if (got_rsp.entry_type !== want_rsp.entry_type)
               report_mismatch("entry_type", got_rsp.entry_type, want_rsp.entry_type);
            if (got_rsp.entry_first !== want_rsp.entry_first)
               report_mismatch("entry_first", got_rsp.entry_first, want_rsp.entry_first);
            if (got_rsp.entry_last !== want_rsp.entry_last)
               report_mismatch("entry_last", got_rsp.entry_last, want_rsp.entry_last);
            if (got_rsp.article_done !== want_rsp.article_done)
               report_mismatch("article_done", got_rsp.article_done, want_rsp.article_done);
            if (got_rsp.status !== want_rsp.status)
               report_mismatch("status", got_rsp.status, want_rsp.status);
         end
      end
   end

   // receiver stall pattern, with long hold-offs on request
   always @(posedge clock) begin
      if (hold_seen != hold_trigger) begin
         hold_seen = hold_trigger;
         hold_left = hold_len;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= stall_pct != 0 && $urandom_range(99) < stall_pct;
      end
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic set_traffic(input int gaps, input int bursts, input int stalls);
      gap_max = gaps;
      burst_max = bursts;
      stall_pct = stalls;
      burst_left = 0;
   endtask

   task automatic shuffle_traffic();
      set_traffic($urandom_range(3) == 0 ? 0 : $urandom_range(8, 1), $urandom_range(16, 1),
                  $urandom_range(3) == 0 ? 0 : $urandom_range(60, 10));
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (burst_left == 0) begin
         if (gap_max != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(gap_max, 1)) @(posedge clock);
         end
         burst_left = $urandom_range(burst_max, 1);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_article_end <= fin;
      do @(posedge clock); while (req_stall);
      expected_rsp = {expected_rsp, parse_byte(b, fin)};
      sent_count++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_rsp.size() != 0);
   endtask

   task automatic write_reg(input logic [tesp_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [55:0] val);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == tesp_pkg::CSR_TYPE_COUNT) cfg_count = val[2:0];
      else cfg_list = val;
   endtask

   task automatic write_count(input logic [2:0] cnt);
      logic [55:0] v;
      v = 56'({$urandom, $urandom});
      v[2:0] = cnt;
      write_reg(tesp_pkg::CSR_TYPE_COUNT, v);
   endtask

   function automatic logic [7:0] rand_letter();
      return $urandom_range(1) ? 8'($urandom_range(8'h7a, 8'h61))
                               : 8'($urandom_range(8'h5a, 8'h41));
   endfunction

   function automatic logic [55:0] rand_list();
      logic [55:0] v;
      for (int k = 0; k < 7; k++)
         v[8*k +: 8] = $urandom_range(9) == 0 ? 8'($urandom_range(255)) : rand_letter();
      return v;
   endfunction

   function automatic int entry_len();
      return $urandom_range(7) == 0 ? $urandom_range(24) : $urandom_range(4);
   endfunction

   task automatic add_byte(input logic [7:0] v);
      art_bytes = {art_bytes, v};
   endtask

   task automatic add_text(input int len);
      repeat (len) add_byte(8'($urandom_range(255, 1)));
      add_byte(8'h00);
   endtask

   task automatic add_counted(input int len);
      logic [31:0] l;
      l = len;
      for (int k = 3; k >= 0; k--) add_byte(l[8*k +: 8]);
      repeat (len) add_byte(8'($urandom_range(255)));
   endtask

   task automatic maybe_truncate();
      int keep;
      if ($urandom_range(9) == 0) begin
         keep = $urandom_range(art_bytes.size(), 1);
         while (art_bytes.size() > keep) void'(art_bytes.pop_back());
      end
   endtask

   task automatic build_inline_article();
      logic [7:0] t;
      repeat ($urandom_range(4, 1)) begin
         t = $urandom_range(11) == 0 ? 8'($urandom_range(255)) : rand_letter();
         add_byte(t);
         if (lc_letter(t)) add_text(entry_len());
         else if (uc_letter(t)) add_counted(entry_len());
      end
      maybe_truncate();
   endtask

   task automatic build_listed_article();
      int         n_fixed;
      logic [7:0] t;
      n_fixed = cfg_count;
      first_entry_end = -1;
      for (int k = 0; k < n_fixed - 1; k++) begin
         t = list_entry(k);
         if (lc_letter(t)) add_text(entry_len());
         else if (uc_letter(t)) add_counted(entry_len());
         else add_byte(8'($urandom_range(255)));
         if (k == 0) first_entry_end = art_bytes.size();
      end
      repeat ($urandom_range(3) == 0 ? 0 : $urandom_range(8, 1))
         add_byte(8'($urandom_range(255)));
      if (art_bytes.size() == 0) add_byte(8'($urandom_range(255)));
      maybe_truncate();
   endtask

   // change_at: byte position before which type_count is rewritten, -1 for none
   task automatic send_article(input int change_at);
      int n;
      n = art_bytes.size();
      for (int i = 0; i < n; i++) begin
         if (i == change_at) write_count(3'($urandom_range(7, 1)));
         send_byte(art_bytes[i], i == n - 1);
      end
      art_bytes.delete();
   endtask

   task automatic send_list(input logic [7:0] bytes[$]);
      art_bytes = bytes;
      send_article(-1);
   endtask

   task automatic test_inline_cases();
      set_traffic(3, 4, 25);
      // held text byte, empty counted entry, empty text entry
      send_list('{8'h6b, 8'h68, 8'h69, 8'h00, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h61, 8'h00});
      // non-letter type, rest dropped
      send_list('{8'h31, 8'h7a});
      // article ends on its type byte
      send_list('{8'h5a});
      // all-ones length, article ends in body
      send_list('{8'h51, 8'hff, 8'hff, 8'hff, 8'hff, 8'h80});
      // article ends inside length
      send_list('{8'h57, 8'h00, 8'h00});
   endtask

   task automatic test_listed_cases();
      write_reg(tesp_pkg::CSR_TYPE_LIST, {32'h0, "C", "b", "a"});
      write_count(3'd3);
      // short article: ends with two listed entries to go
      send_list('{8'h78, 8'h00});
      write_reg(tesp_pkg::CSR_TYPE_LIST, {40'h0, 8'h00, "a"});
      write_count(3'd2);
      // ends before a non-letter last entry
      send_list('{8'h78, 8'h00});
      write_reg(tesp_pkg::CSR_TYPE_LIST, {40'h0, "a", "#"});
      // non-letter listed type on first byte
      send_list('{8'h55});
      write_reg(tesp_pkg::CSR_TYPE_LIST, {48'h0, "R"});
      write_count(3'd1);
      // single listed entry takes the whole article
      send_list('{8'h00, 8'hff});
   endtask

   task automatic test_random_inline();
      int stop;
      write_count(3'd0);
      stop = sent_count + 330;
      while (sent_count < stop) begin
         if ($urandom_range(5) == 0) shuffle_traffic();
         build_inline_article();
         send_article(-1);
      end
   endtask

   task automatic test_random_listed();
      int stop;
      int cfg_no;
      int change_at;
      stop = sent_count + 300;
      cfg_no = 0;
      while (sent_count < stop) begin
         write_reg(tesp_pkg::CSR_TYPE_LIST, rand_list());
         write_count(cfg_no == 0 ? 3'd7 : cfg_no == 1 ? 3'd1 : 3'($urandom_range(7)));
         shuffle_traffic();
         repeat ($urandom_range(6, 2)) begin
            change_at = -1;
            if (cfg_count == 3'd0) begin
               build_inline_article();
            end else begin
               build_listed_article();
               if (first_entry_end > 0 && first_entry_end < art_bytes.size() &&
                   $urandom_range(5) == 0)
                  change_at = first_entry_end;
            end
            send_article(change_at);
         end
         cfg_no++;
      end
   endtask

   task automatic test_noise();
      int stop;
      stop = sent_count + 120;
      while (sent_count < stop) begin
         write_reg(tesp_pkg::CSR_TYPE_LIST, 56'({$urandom, $urandom}));
         write_count(3'($urandom_range(7)));
         shuffle_traffic();
         repeat ($urandom_range(4, 1)) begin
            repeat ($urandom_range(8, 1)) add_byte(8'($urandom_range(255)));
            send_article(-1);
         end
      end
   endtask

   task automatic test_backpressure();
      int stop;
      write_count(3'd0);
      set_traffic(0, 1, 0);
      hold_len = 60;
      hold_trigger++;
      stop = sent_count + 40;
      while (sent_count < stop) begin
         build_inline_article();
         send_article(-1);
      end
      drain_results();
      write_reg(tesp_pkg::CSR_TYPE_LIST, rand_list());
      write_count(3'd3);
      set_traffic(4, 8, 30);
      hold_len = 80;
      hold_trigger++;
      stop = sent_count + 40;
      while (sent_count < stop) begin
         build_listed_article();
         send_article(-1);
      end
      drain_results();
   endtask

   initial begin
      cfg_count = 3'd0;
      cfg_list = 56'h0;
      cur_type = 8'h00;
      restart_parse();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_inline_cases();
      test_listed_cases();
      test_random_inline();
      test_random_listed();
      test_noise();
      test_backpressure();
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/tesp_pkg.sv
sv/tesp_in_reg.sv
sv/tesp_core.sv
sv/tesp_out_reg.sv
sv/typed_entry_stream_parser_top.sv
tb/tb.sv
